>>> rtl/chained_hash_map_engine_macros.svh
// Assertion macros for the chained hash map engine checker.
// Included by the checker file only; no other dependencies.
`ifndef CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/chm_pkg.sv
// Shared widths and codes for the chained hash map engine.
// No dependencies; used by the top level and the checker.
`default_nettype none

package chm_pkg;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 4;
    localparam int WVAL_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int TOTAL_W   = 10;
    localparam int KEY_BYTES = 8;

    typedef enum logic [OP_W-1:0] {
        OP_SET    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED    = 3'd0,
        ST_OVERWRITTEN = 3'd1,
        ST_FOUND       = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_REMOVED     = 3'd4,
        ST_FULL        = 3'd5
    } status_t;

endpackage

`default_nettype wire

>>> rtl/chained_hash_map_engine.sv
// Top level of the chained hash map engine: request decode, hash fold,
// slot scan sequencer and result register. Uses chm_pkg, chm_slot_mem, chm_fill_mem.
//
//   channel   ports                                             direction
//   request   s_valid s_ready s_operation s_key s_key_bytes     in
//             s_write_value
//   result    m_valid m_ready m_status m_read_value             out
//             m_entry_total
//
// A request passes through the fill read, the slot scan (n slots compared: the fill on a
// miss, match position + 1 on a hit), the act step, a move step for a remove that moves
// the last entry, and the result step. The scan compares one slot per cycle.
// After reset the fill counts are swept to zero; s_ready stays low.
// A request is taken while an earlier result waits in the output register; a stalled
// result holds the sequencer in its final step until m_ready.
`default_nettype none

module chained_hash_map_engine #(
    parameter int BUCKETS          = 64,
    parameter int SLOTS_PER_BUCKET = 8,
    parameter int VALUE_BITS       = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [chm_pkg::OP_W-1:0]         s_operation,
    input  wire logic [chm_pkg::KEY_W-1:0]        s_key,
    input  wire logic [chm_pkg::LEN_W-1:0]        s_key_bytes,
    input  wire logic [chm_pkg::WVAL_W-1:0]       s_write_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [chm_pkg::STATUS_W-1:0]     m_status,
    output logic      [chm_pkg::WVAL_W-1:0]       m_read_value,
    output logic      [chm_pkg::TOTAL_W-1:0]      m_entry_total
);

    localparam int TOTAL_SLOTS = BUCKETS * SLOTS_PER_BUCKET;
    localparam int SLOT_AW     = $clog2(TOTAL_SLOTS);
    localparam int BUCKET_W    = $clog2(BUCKETS);
    localparam int FILL_W      = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int ENTRY_W     = chm_pkg::KEY_W + chm_pkg::LEN_W + VALUE_BITS;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_FILL  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_ACT   = 7'b0010000,
        S_MOVE  = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // request fields, decoded at accept
    logic [chm_pkg::LEN_W-1:0]  len_in;
    logic [chm_pkg::KEY_W-1:0]  key_in;
    logic [chm_pkg::KEY_W-1:0]  h1, h2;
    logic [BUCKET_W-1:0]        bucket_in;

    logic [chm_pkg::OP_W-1:0]   op_reg, op_next;
    logic [chm_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [chm_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [VALUE_BITS-1:0]      val_reg, val_next;
    logic [BUCKET_W-1:0]        bucket_reg, bucket_next;
    logic [SLOT_AW-1:0]         base_reg, base_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [FILL_W-1:0]          fill_last;
    logic [FILL_W-1:0]          rd_idx_reg, rd_idx_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [FILL_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                       hit_reg, hit_next;
    logic [FILL_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [VALUE_BITS-1:0]      hit_val_reg, hit_val_next;
    chm_pkg::status_t           res_status_reg, res_status_next;
    logic [chm_pkg::WVAL_W-1:0] res_value_reg, res_value_next;
    logic [chm_pkg::TOTAL_W-1:0] count_reg, count_next;

    logic                        m_valid_reg, m_valid_next;
    logic [chm_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [chm_pkg::WVAL_W-1:0]  m_read_value_reg, m_read_value_next;
    logic [chm_pkg::TOTAL_W-1:0] m_entry_total_reg, m_entry_total_next;

    // memory ports
    logic                 slot_we;
    logic [SLOT_AW-1:0]   slot_waddr, slot_raddr;
    logic [ENTRY_W-1:0]   slot_wdata, slot_rdata;
    logic                 fill_we;
    logic [FILL_W-1:0]    fill_wdata, fill_rdata;
    logic                 fill_busy;

    // compare unit, shared by every slot of the scan
    logic [chm_pkg::KEY_W-1:0] rd_key;
    logic [chm_pkg::LEN_W-1:0] rd_len;
    logic [VALUE_BITS-1:0]     rd_val;
    logic                      cmp_hit;

    always_comb begin
        len_in = (s_key_bytes > chm_pkg::LEN_W'(chm_pkg::KEY_BYTES))
               ? chm_pkg::LEN_W'(chm_pkg::KEY_BYTES) : s_key_bytes;
        for (int i = 0; i < chm_pkg::KEY_BYTES; i++) begin
            key_in[8*i +: 8] = (chm_pkg::LEN_W'(i) < len_in) ? s_key[8*i +: 8] : 8'h00;
        end
        h1 = key_in ^ (key_in >> 32);
        h2 = h1 ^ (h1 >> 16);
        bucket_in = BUCKET_W'(h2[15:0] & 16'(BUCKETS - 1));
    end

    assign rd_val  = slot_rdata[VALUE_BITS-1:0];
    assign rd_len  = slot_rdata[VALUE_BITS +: chm_pkg::LEN_W];
    assign rd_key  = slot_rdata[VALUE_BITS + chm_pkg::LEN_W +: chm_pkg::KEY_W];
    assign cmp_hit = cmp_vld_reg && (rd_len == len_reg) && (rd_key == key_reg);

    assign fill_last = fill_reg - 1'b1;

    always_comb begin
        state_next         = state_reg;
        op_next            = op_reg;
        key_next           = key_reg;
        len_next           = len_reg;
        val_next           = val_reg;
        bucket_next        = bucket_reg;
        base_next          = base_reg;
        fill_next          = fill_reg;
        rd_idx_next        = rd_idx_reg;
        cmp_vld_next       = cmp_vld_reg;
        cmp_idx_next       = cmp_idx_reg;
        hit_next           = hit_reg;
        hit_idx_next       = hit_idx_reg;
        hit_val_next       = hit_val_reg;
        res_status_next    = res_status_reg;
        res_value_next     = res_value_reg;
        count_next         = count_reg;
        m_valid_next       = m_valid_reg;
        m_status_next      = m_status_reg;
        m_read_value_next  = m_read_value_reg;
        m_entry_total_next = m_entry_total_reg;

        slot_we    = 1'b0;
        slot_waddr = base_reg + SLOT_AW'(hit_idx_reg);
        slot_wdata = {key_reg, len_reg, val_reg};
        slot_raddr = base_reg + SLOT_AW'(rd_idx_reg);
        fill_we    = 1'b0;
        fill_wdata = fill_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                if (!fill_busy) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_operation;
                    key_next    = key_in;
                    len_next    = len_in;
                    val_next    = VALUE_BITS'(s_write_value);
                    bucket_next = bucket_in;
                    base_next   = SLOT_AW'(bucket_in) * SLOT_AW'(SLOTS_PER_BUCKET);
                    state_next  = S_FILL;
                end
            end
            S_FILL: begin
                fill_next    = fill_rdata;
                rd_idx_next  = '0;
                cmp_vld_next = 1'b0;
                state_next   = S_SCAN;
            end
            S_SCAN: begin
                // one slot read issued and the previous one compared each cycle
                if (cmp_hit) begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_val_next = rd_val;
                    state_next   = S_ACT;
                end else if (rd_idx_reg < fill_reg) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end else begin
                    hit_next     = 1'b0;
                    cmp_vld_next = 1'b0;
                    state_next   = S_ACT;
                end
            end
            S_ACT: begin
                res_value_next  = '0;
                res_status_next = chm_pkg::ST_NOT_FOUND;
                state_next      = S_RESP;
                case (op_reg)
                    chm_pkg::OP_SET: begin
                        if (hit_reg) begin
                            slot_we         = 1'b1;
                            res_status_next = chm_pkg::ST_OVERWRITTEN;
                        end else if (fill_reg >= FILL_W'(SLOTS_PER_BUCKET)) begin
                            res_status_next = chm_pkg::ST_FULL;
                        end else begin
                            slot_we         = 1'b1;
                            slot_waddr      = base_reg + SLOT_AW'(fill_reg);
                            fill_we         = 1'b1;
                            fill_wdata      = fill_reg + 1'b1;
                            count_next      = count_reg + 1'b1;
                            res_status_next = chm_pkg::ST_INSERTED;
                        end
                    end
                    chm_pkg::OP_GET: begin
                        if (hit_reg) begin
                            res_value_next  = chm_pkg::WVAL_W'(hit_val_reg);
                            res_status_next = chm_pkg::ST_FOUND;
                        end
                    end
                    chm_pkg::OP_REMOVE: begin
                        if (hit_reg) begin
                            fill_we         = 1'b1;
                            fill_wdata      = fill_last;
                            count_next      = count_reg - 1'b1;
                            res_status_next = chm_pkg::ST_REMOVED;
                            // fetch the bucket's last entry to fill the hole
                            slot_raddr      = base_reg + SLOT_AW'(fill_last);
                            if (hit_idx_reg != fill_last) begin
                                state_next = S_MOVE;
                            end
                        end
                    end
                    default: begin
                        res_status_next = chm_pkg::ST_NOT_FOUND;
                    end
                endcase
            end
            S_MOVE: begin
                slot_we    = 1'b1;
                slot_wdata = slot_rdata;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = res_status_reg;
                    m_read_value_next  = res_value_reg;
                    m_entry_total_next = count_reg;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg            <= op_next;
        key_reg           <= key_next;
        len_reg           <= len_next;
        val_reg           <= val_next;
        bucket_reg        <= bucket_next;
        base_reg          <= base_next;
        fill_reg          <= fill_next;
        rd_idx_reg        <= rd_idx_next;
        cmp_vld_reg       <= cmp_vld_next;
        cmp_idx_reg       <= cmp_idx_next;
        hit_reg           <= hit_next;
        hit_idx_reg       <= hit_idx_next;
        hit_val_reg       <= hit_val_next;
        res_status_reg    <= res_status_next;
        res_value_reg     <= res_value_next;
        m_status_reg      <= m_status_next;
        m_read_value_reg  <= m_read_value_next;
        m_entry_total_reg <= m_entry_total_next;
    end

    chm_slot_mem #(
        .DEPTH  (TOTAL_SLOTS),
        .DATA_W (ENTRY_W)
    ) u_slot_mem (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    chm_fill_mem #(
        .DEPTH  (BUCKETS),
        .DATA_W (FILL_W)
    ) u_fill_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (fill_we),
        .waddr   (bucket_reg),
        .wdata   (fill_wdata),
        .raddr   (bucket_in),
        .rdata   (fill_rdata),
        .busy    (fill_busy)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_entry_total = m_entry_total_reg;

endmodule

`default_nettype wire

>>> rtl/chm_slot_mem.sv
// Slot storage: key, length and value of every bucket slot in one word.
// One write port, one read port with registered data. No dependencies.
`default_nettype none

module chm_slot_mem #(
    parameter int  DEPTH  = 512,
    parameter int  DATA_W = 100,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/chm_fill_mem.sv
// Per-bucket fill counts, cleared by a sweep of one bucket per cycle after reset.
// One write port, one registered read port. No dependencies.
`default_nettype none

module chm_fill_mem #(
    parameter int  DEPTH  = 64,
    parameter int  DATA_W = 4,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata,
    output logic                   busy
);

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              busy_reg;
    logic [ADDR_W-1:0] clr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end else if (busy_reg) begin
            if (clr_reg == LAST) begin
                busy_reg <= 1'b0;
            end else begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_reg] <= '0;
        end else if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

`default_nettype wire

>>> rtl/chm_checker.sv
// Port-level checks for the chained hash map engine, bound to the top level.
// Uses chm_pkg and the assertion macros header.
`default_nettype none

`include "chained_hash_map_engine_macros.svh"

module chm_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [chm_pkg::STATUS_W-1:0]     m_status,
    input wire logic [chm_pkg::WVAL_W-1:0]       m_read_value,
    input wire logic [chm_pkg::TOTAL_W-1:0]      m_entry_total
);

    // a stalled result holds
    `CHM_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_read_value) && $stable(m_entry_total), "stalled result changed")

    // only a successful get carries a value
    `CHM_ASSERT_SAME(a_value_zero, aclk, aresetn, m_valid && (m_status != chm_pkg::ST_FOUND), m_read_value == '0, "read value nonzero without a hit")

    // one request at a time: busy right after an accept
    `CHM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready right after accept")

endmodule

bind chained_hash_map_engine chm_checker u_chm_checker (.*);

`default_nettype wire

>>> bench/tb_chained_hash_map_engine.sv
// Self-checking bench for chained_hash_map_engine: directed and random set/get/remove
// requests under random handshake stalls, checked against a bucket-level shadow store.
// Depends on chm_pkg and the chained_hash_map_engine RTL only.
`timescale 1ns / 1ps

module tb_chained_hash_map_engine;

    localparam int BUCKETS      = 64;
    localparam int SLOTS        = 8;
    localparam int POOL_SIZE    = 48;
    localparam int RANDOM_ITEMS = 500;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;

    // operation code with no meaning to the block
    localparam logic [chm_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef struct {
        chm_pkg::status_t             status;
        logic [chm_pkg::WVAL_W-1:0]   read_value;
        logic [chm_pkg::TOTAL_W-1:0]  entry_total;
    } map_reply_t;

    // Shadow of the bucket store; predicts one reply per request.
    class hash_map_mirror;
        logic [chm_pkg::KEY_W-1:0]  shadow_keys [BUCKETS*SLOTS];
        int                         shadow_lens [BUCKETS*SLOTS];
        logic [chm_pkg::WVAL_W-1:0] shadow_vals [BUCKETS*SLOTS];
        int                         shadow_fill [BUCKETS];
        int                         shadow_count;
        map_reply_t                 replies_due[$];
        int                         errors;
        int                         requests;
        int                         status_seen [6];

        function new();
            for (int i = 0; i < BUCKETS; i++) shadow_fill[i] = 0;
            for (int i = 0; i < 6; i++) status_seen[i] = 0;
            shadow_count = 0;
            errors = 0;
            requests = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void apply_request(logic [chm_pkg::OP_W-1:0] op,
                                    logic [chm_pkg::KEY_W-1:0] key,
                                    logic [chm_pkg::LEN_W-1:0] nbytes,
                                    logic [chm_pkg::WVAL_W-1:0] wval);
            int len;
            int b;
            int base;
            int fill;
            int idx;
            int last;
            logic [chm_pkg::KEY_W-1:0] k;
            logic [chm_pkg::KEY_W-1:0] h;
            map_reply_t r;
            len = int'(nbytes);
            if (len > chm_pkg::KEY_BYTES) len = chm_pkg::KEY_BYTES;
            k = '0;
            for (int i = 0; i < len; i++) k[8*i +: 8] = key[8*i +: 8];
            h = k ^ (k >> 32);
            h = h ^ (h >> 16);
            b = int'(h & 64'(BUCKETS - 1));
            base = b * SLOTS;
            fill = shadow_fill[b];
            idx = -1;
            for (int i = 0; i < fill; i++) begin
                if (idx < 0 && shadow_lens[base+i] == len && shadow_keys[base+i] == k)
                    idx = i;
            end
            r.status = chm_pkg::ST_NOT_FOUND;
            r.read_value = '0;
            case (op)
                chm_pkg::OP_SET: begin
                    if (idx >= 0) begin
                        shadow_vals[base+idx] = wval;
                        r.status = chm_pkg::ST_OVERWRITTEN;
                    end else if (fill >= SLOTS) begin
                        r.status = chm_pkg::ST_FULL;
                    end else begin
                        shadow_keys[base+fill] = k;
                        shadow_lens[base+fill] = len;
                        shadow_vals[base+fill] = wval;
                        shadow_fill[b] = fill + 1;
                        shadow_count++;
                        r.status = chm_pkg::ST_INSERTED;
                    end
                end
                chm_pkg::OP_GET: begin
                    if (idx >= 0) begin
                        r.read_value = shadow_vals[base+idx];
                        r.status = chm_pkg::ST_FOUND;
                    end
                end
                chm_pkg::OP_REMOVE: begin
                    if (idx >= 0) begin
                        // freed slot takes the bucket's last entry
                        last = base + fill - 1;
                        shadow_keys[base+idx] = shadow_keys[last];
                        shadow_lens[base+idx] = shadow_lens[last];
                        shadow_vals[base+idx] = shadow_vals[last];
                        shadow_fill[b] = fill - 1;
                        shadow_count--;
                        r.status = chm_pkg::ST_REMOVED;
                    end
                end
                default: ;
            endcase
            r.entry_total = chm_pkg::TOTAL_W'(shadow_count);
            replies_due.push_back(r);
            requests++;
        endfunction

        function void compare_reply(logic [chm_pkg::STATUS_W-1:0] status,
                                    logic [chm_pkg::WVAL_W-1:0] rval,
                                    logic [chm_pkg::TOTAL_W-1:0] total);
            map_reply_t r;
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply, status %0d value %h total %0d",
                         $time, status, rval, total);
                return;
            end
            r = replies_due.pop_front();
            if (int'(r.status) < 6) status_seen[int'(r.status)]++;
            if (status !== r.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, r.status, status);
            end
            if (rval !== r.read_value) begin
                errors++;
                $display("%0t: read_value mismatch, expected %h actual %h",
                         $time, r.read_value, rval);
            end
            if (total !== r.entry_total) begin
                errors++;
                $display("%0t: entry_total mismatch, expected %0d actual %0d",
                         $time, r.entry_total, total);
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [chm_pkg::OP_W-1:0]      s_operation;
    logic [chm_pkg::KEY_W-1:0]     s_key;
    logic [chm_pkg::LEN_W-1:0]     s_key_bytes;
    logic [chm_pkg::WVAL_W-1:0]    s_write_value;
    logic                          m_valid;
    logic                          m_ready;
    logic [chm_pkg::STATUS_W-1:0]  m_status;
    logic [chm_pkg::WVAL_W-1:0]    m_read_value;
    logic [chm_pkg::TOTAL_W-1:0]   m_entry_total;

    hash_map_mirror mirror = new();

    bit tx_fast;
    bit rx_fast;
    int rx_hold;

    logic [chm_pkg::KEY_W-1:0] pool_key [POOL_SIZE];
    logic [chm_pkg::LEN_W-1:0] pool_len [POOL_SIZE];

    chained_hash_map_engine #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS),
        .VALUE_BITS       (chm_pkg::WVAL_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_key         (s_key),
        .s_key_bytes   (s_key_bytes),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_entry_total (m_entry_total)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Random key of len bytes whose fold lands in the given bucket.
    function automatic logic [chm_pkg::KEY_W-1:0] make_key(int bucket, int len);
        logic [chm_pkg::KEY_W-1:0] raw;
        logic [chm_pkg::KEY_W-1:0] k;
        logic [5:0] rest;
        raw = {$urandom, $urandom};
        k = '0;
        for (int i = 0; i < len; i++) k[8*i +: 8] = raw[8*i +: 8];
        if (len == 0) return k;
        rest = k[21:16] ^ k[37:32] ^ k[53:48];
        k[5:0] = 6'(bucket) ^ rest;
        return k;
    endfunction

    // Mostly keys in four hot buckets so they fill up; last four entries reuse an
    // earlier key with one more length byte (same bytes, different identity).
    function automatic void refresh_pool();
        int hot [4];
        int len;
        for (int j = 0; j < 4; j++) hot[j] = $urandom_range(0, BUCKETS - 1);
        for (int i = 0; i < POOL_SIZE - 4; i++) begin
            len = (i < 4) ? $urandom_range(1, 7) : $urandom_range(1, 8);
            if (i < 36)
                pool_key[i] = make_key(hot[i % 4], len);
            else
                pool_key[i] = make_key($urandom_range(0, BUCKETS - 1), len);
            pool_len[i] = chm_pkg::LEN_W'(len);
        end
        for (int i = POOL_SIZE - 4; i < POOL_SIZE; i++) begin
            pool_key[i] = pool_key[i - (POOL_SIZE - 4)];
            pool_len[i] = pool_len[i - (POOL_SIZE - 4)] + 4'd1;
        end
    endfunction

    task automatic send_request(input logic [chm_pkg::OP_W-1:0] op,
                                input logic [chm_pkg::KEY_W-1:0] key,
                                input logic [chm_pkg::LEN_W-1:0] nbytes,
                                input logic [chm_pkg::WVAL_W-1:0] wval);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_operation   = op;
        s_key         = key;
        s_key_bytes   = nbytes;
        s_write_value = wval;
        do @(posedge aclk); while (!s_ready);
        mirror.apply_request(op, key, nbytes, wval);
    endtask

    task automatic send_random();
        int roll;
        int pick;
        int shift;
        chm_pkg::op_t op;
        logic [chm_pkg::KEY_W-1:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            // noise: any op code, any key, any length code
            send_request(chm_pkg::OP_W'($urandom_range(0, 3)), {$urandom, $urandom},
                         chm_pkg::LEN_W'($urandom_range(0, 15)), $urandom);
        end else begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            roll = $urandom_range(0, 99);
            if (roll < 45)
                op = chm_pkg::OP_SET;
            else if (roll < 78)
                op = chm_pkg::OP_GET;
            else
                op = chm_pkg::OP_REMOVE;
            k = pool_key[pick];
            shift = 8 * int'(pool_len[pick]);
            if (shift < chm_pkg::KEY_W && $urandom_range(0, 2) == 0)
                k = k | ({$urandom, $urandom} << shift);
            send_request(op, k, pool_len[pick], $urandom);
        end
    endtask

    task automatic wait_all_replies();
        @(negedge aclk);
        s_valid = 1'b0;
        while (mirror.pending() != 0) @(posedge aclk);
    endtask

    // result side
    initial begin
        int wait_cycles;
        wait (aresetn === 1'b1);
        forever begin
            wait_cycles = rx_fast ? 0 : $urandom_range(0, 10);
            if (rx_hold > 0) begin
                wait_cycles = rx_hold;
                rx_hold = 0;
            end
            @(negedge aclk);
            if (wait_cycles > 0) begin
                m_ready = 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            mirror.compare_reply(m_status, m_read_value, m_entry_total);
        end
    end

    // watchdog: too long without any handshake on either side
    initial begin
        int idle;
        idle = 0;
        wait (aresetn === 1'b1);
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tb_chained_hash_map_engine: done, errors");
        $finish;
    end

    initial begin
        logic [chm_pkg::KEY_W-1:0] row [9];
        int directed;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_operation   = '0;
        s_key         = '0;
        s_key_bytes   = '0;
        s_write_value = '0;
        m_ready       = 1'b0;
        tx_fast       = 1'b0;
        rx_fast       = 1'b0;
        rx_hold       = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty store, extremes, masking, odd lengths, unknown op
        send_request(chm_pkg::OP_GET, '1, 4'd8, '0);
        send_request(chm_pkg::OP_REMOVE, '1, 4'd8, '0);
        send_request(chm_pkg::OP_SET, '1, 4'd8, '1);
        send_request(chm_pkg::OP_GET, '1, 4'd8, '0);
        send_request(chm_pkg::OP_SET, '1, 4'd8, '0);
        send_request(chm_pkg::OP_SET, '0, 4'd1, 32'h1234_5678);
        send_request(chm_pkg::OP_SET, '0, 4'd2, 32'h9abc_def0);
        send_request(chm_pkg::OP_GET, '0, 4'd2, '0);
        send_request(chm_pkg::OP_SET, 64'hdead_beef_0000_0011, 4'd1, 32'h0bad_cafe);
        send_request(chm_pkg::OP_GET, 64'h0000_0000_0000_0011, 4'd1, '0);
        send_request(chm_pkg::OP_SET, 64'h0000_0000_0000_abcd, 4'd0, 32'h5555_aaaa);
        send_request(chm_pkg::OP_GET, 64'h0000_0000_0000_0055, 4'd0, '0);
        send_request(chm_pkg::OP_SET, 64'h0123_4567_89ab_cdef, 4'd12, 32'hfeed_f00d);
        send_request(chm_pkg::OP_GET, 64'h0123_4567_89ab_cdef, 4'd8, '0);
        send_request(OP_UNKNOWN, '1, 4'd8, '1);
        // fill one bucket, overflow it, then remove from the front
        for (int i = 0; i < 9; i++) begin
            row[i] = make_key(5, 8);
            send_request(chm_pkg::OP_SET, row[i], 4'd8, $urandom);
        end
        send_request(chm_pkg::OP_REMOVE, row[0], 4'd8, '0);
        send_request(chm_pkg::OP_GET, row[7], 4'd8, '0);
        directed = mirror.requests;

        refresh_pool();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150) rx_hold = LONG_HOLD;
            if (n == 250) refresh_pool();
            if (n == 300) wait_all_replies();
            tx_fast = (n >= 350 && n < 420);
            rx_fast = tx_fast;
            send_random();
        end
        @(negedge aclk);
        s_valid = 1'b0;

        while (mirror.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d directed), long result stall, full drain",
                 mirror.requests, directed);
        $display("replies: %0d inserted %0d overwritten %0d found %0d missing %0d removed %0d full",
                 mirror.status_seen[chm_pkg::ST_INSERTED],
                 mirror.status_seen[chm_pkg::ST_OVERWRITTEN],
                 mirror.status_seen[chm_pkg::ST_FOUND],
                 mirror.status_seen[chm_pkg::ST_NOT_FOUND],
                 mirror.status_seen[chm_pkg::ST_REMOVED],
                 mirror.status_seen[chm_pkg::ST_FULL]);
        if (mirror.errors == 0) begin
            $display("tb_chained_hash_map_engine: done, clean");
        end else begin
            $display("tb_chained_hash_map_engine: done, errors");
        end
        $finish;
    end

endmodule
